/* rtl/hts_pkg.sv */
package hts_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 8;
  localparam int unsigned MAX_RESULTS   = 8;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [1:0] FUNC_ADD      = 2'd2;
  localparam logic [1:0] FUNC_DELETE   = 2'd3;

  localparam logic [1:0] KIND_PRE  = 2'd0;
  localparam logic [1:0] KIND_COOP = 2'd1;
  localparam logic [1:0] KIND_ADD  = 2'd2;
  localparam logic [1:0] KIND_DEL  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  slot_index;
    logic [7:0]  task_code;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic        cooperative;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [3:0] result_slot;
    logic [7:0] result_task;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  // One entry of the slot table memory. Occupancy is kept in flops outside.
  typedef struct packed {
    logic [7:0]  tcode;
    logic [15:0] delay;
    logic [15:0] period;
    logic        coop;
    logic [7:0]  pend_cnt;
  } slot_ent_t;

  typedef struct packed {
    logic wr;
    logic clr_valid;
    logic emit;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ADD,
    ST_FLUSH
  } sched_state_t;

endpackage

/* rtl/hts_slot_upd.sv */
module hts_slot_upd (
  input  logic              is_tick,
  input  logic              vld,
  input  hts_pkg::slot_ent_t ent,
  output hts_pkg::slot_ent_t ent_nxt,
  output hts_pkg::upd_t     upd
);
  import hts_pkg::*;

  always_comb begin
    ent_nxt = ent;
    upd     = '0;
    if (vld) begin
      if (is_tick) begin
        upd.wr = 1'b1;
        if (ent.delay != 16'd0) begin
          ent_nxt.delay = ent.delay - 16'd1;
        end else begin
          if (ent.coop) begin
            if (ent.pend_cnt != 8'hFF) begin
              ent_nxt.pend_cnt = ent.pend_cnt + 8'd1;
            end
          end else begin
            upd.emit = 1'b1;
            upd.clr_valid = (ent.period == 16'd0);
          end
          if (ent.period != 16'd0) begin
            ent_nxt.delay = ent.period;
          end
        end
      end else if (ent.coop && (ent.pend_cnt != 8'd0)) begin
        upd.wr           = 1'b1;
        upd.emit         = 1'b1;
        upd.clr_valid    = (ent.period == 16'd0);
        ent_nxt.pend_cnt = ent.pend_cnt - 8'd1;
      end
    end
  end

endmodule

/* rtl/hybrid_task_scheduler.sv */
// Channel | Ports                        | Word
// input   | in_valid, in_ready, in_data  | in_item_t: one command
// result  | out_valid, out_ready, out_data | out_item_t: one result
//
// Tick and dispatch walk the slot table through a read port and a write port,
// one slot per cycle while a full output register does not hold the walk.
// Add scans the occupancy flops, one slot per cycle; delete goes straight from idle
// to the flush step. A new command is taken once the previous one is done.
// rst_n is synchronous; the table starts empty, no clearing pass is needed.
// A full output register holds the walk until the result word is taken.
module hybrid_task_scheduler #(
  parameter int unsigned NUM_SLOTS = hts_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hts_pkg::out_item_t out_data
);
  import hts_pkg::*;

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  sched_state_t state_r, state_nxt;

  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  in_item_t             cmd_r, cmd_nxt;
  logic [IW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 rd_done_r, rd_done_nxt;
  logic                 s1_v_r, s1_v_nxt;
  logic [IW-1:0]        s1_idx_r, s1_idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  out_item_t            pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic                 out_vld_r, out_vld_nxt;

  slot_ent_t            mem [NUM_SLOTS];
  slot_ent_t            rdata_r;
  logic                 mem_we, mem_re;
  logic [IW-1:0]        mem_waddr;
  slot_ent_t            mem_wdata;

  slot_ent_t            upd_ent;
  upd_t                 upd;
  logic                 advance;
  logic                 out_load;
  out_item_t            out_load_data;

  hts_slot_upd u_upd (
    .is_tick (cmd_r.func == FUNC_TICK),
    .vld     (valid_r[s1_idx_r]),
    .ent     (rdata_r),
    .ent_nxt (upd_ent),
    .upd     (upd)
  );

  assign advance   = !(out_vld_r && !out_ready);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_idx_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            FUNC_ADD:    state_nxt = ST_ADD;
            FUNC_DELETE: state_nxt = ST_FLUSH;
            default:     state_nxt = ST_WALK;
          endcase
        end
      end
      ST_WALK: begin
        if (advance && rd_done_r) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_ADD: begin
        if (!valid_r[rd_idx_r] || (rd_idx_r == LAST_IDX)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || advance) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt     = valid_r;
    cmd_nxt       = cmd_r;
    rd_idx_nxt    = rd_idx_r;
    rd_done_nxt   = rd_done_r;
    s1_v_nxt      = s1_v_r;
    s1_idx_nxt    = s1_idx_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = s1_idx_r;
    mem_wdata     = upd_ent;
    out_load      = 1'b0;
    out_load_data = pend_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data;
          cnt_nxt     = '0;
          rd_idx_nxt  = '0;
          rd_done_nxt = 1'b0;
          s1_v_nxt    = 1'b0;
          if (in_data.func == FUNC_DELETE) begin
            pend_nxt.result_kind = KIND_DEL;
            pend_nxt.result_slot = 4'(in_data.slot_index);
            pend_nxt.result_task = 8'd0;
            pend_nxt.last_of_run = 1'b0;
            pend_nxt.status      = STAT_EMPTY;
            if (int'(in_data.slot_index) < NUM_SLOTS) begin
              if (valid_r[IW'(in_data.slot_index)]) begin
                pend_nxt.status = STAT_OK;
              end
              valid_nxt[IW'(in_data.slot_index)] = 1'b0;
            end
            pend_v_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (advance) begin
          if (s1_v_r) begin
            mem_we = upd.wr;
            if (upd.clr_valid) begin
              valid_nxt[s1_idx_r] = 1'b0;
            end
            // Results past the cap are dropped; the slot state still updates.
            if (upd.emit && (cnt_r < CNT_W'(MAX_RESULTS))) begin
              cnt_nxt              = cnt_r + CNT_W'(1);
              pend_nxt.result_kind = (cmd_r.func == FUNC_TICK) ? KIND_PRE : KIND_COOP;
              pend_nxt.result_slot = 4'(s1_idx_r);
              pend_nxt.result_task = rdata_r.tcode;
              pend_nxt.status      = STAT_OK;
              pend_nxt.last_of_run = 1'b0;
              pend_v_nxt           = 1'b1;
              // The held word is known not to be the last one, so it goes out now.
              out_load = pend_v_r;
            end
          end
          if (!rd_done_r) begin
            mem_re      = 1'b1;
            s1_v_nxt    = 1'b1;
            s1_idx_nxt  = rd_idx_r;
            rd_done_nxt = (rd_idx_r == LAST_IDX);
            rd_idx_nxt  = rd_idx_r + IW'(1);
          end else begin
            s1_v_nxt = 1'b0;
          end
        end
      end
      ST_ADD: begin
        mem_waddr        = rd_idx_r;
        mem_wdata.tcode  = cmd_r.task_code;
        mem_wdata.delay  = cmd_r.first_delay;
        mem_wdata.period = cmd_r.repeat_period;
        mem_wdata.coop   = cmd_r.cooperative;
        mem_wdata.pend_cnt = 8'd0;
        pend_nxt.result_kind = KIND_ADD;
        pend_nxt.result_task = 8'd0;
        pend_nxt.last_of_run = 1'b0;
        if (!valid_r[rd_idx_r]) begin
          mem_we               = 1'b1;
          valid_nxt[rd_idx_r]  = 1'b1;
          pend_nxt.result_slot = 4'(rd_idx_r);
          pend_nxt.status      = STAT_OK;
          pend_v_nxt           = 1'b1;
        end else if (rd_idx_r == LAST_IDX) begin
          pend_nxt.result_slot = 4'(NUM_SLOTS);
          pend_nxt.status      = STAT_FULL;
          pend_v_nxt           = 1'b1;
        end else begin
          rd_idx_nxt = rd_idx_r + IW'(1);
        end
      end
      ST_FLUSH: begin
        if (advance && pend_v_r) begin
          out_load                  = 1'b1;
          out_load_data.last_of_run = 1'b1;
          pend_v_nxt                = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    if (out_load) begin
      out_data_nxt = out_load_data;
      out_vld_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      rd_idx_r  <= '0;
      rd_done_r <= 1'b0;
      s1_v_r    <= 1'b0;
      cnt_r     <= '0;
      pend_v_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      rd_idx_r  <= rd_idx_nxt;
      rd_done_r <= rd_done_nxt;
      s1_v_r    <= s1_v_nxt;
      cnt_r     <= cnt_nxt;
      pend_v_r  <= pend_v_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    s1_idx_r   <= s1_idx_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!pend_v_r && !s1_v_r))
    else $error("command accepted while a result or slot was still in flight");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("result count exceeded the cap");

  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_load_data.last_of_run) |-> (state_r == ST_FLUSH))
    else $error("final result word loaded outside the flush step");

  a_walk_no_read_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!mem_we && !mem_re))
    else $error("slot table accessed while idle");
`endif

endmodule
